[rtl/msps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types, constants and helpers for the multi-stepper position
// sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

   localparam int MOTORS_DEFAULT = 4;
   localparam int ADDR_SLOTS     = 4;
   localparam int ADDR_W         = 7;
   localparam int POS_W          = 32;
   localparam int MOTOR_W        = 3;
   localparam int IDX_W          = 2;
   localparam int CNT_W          = 3;
   localparam int MASK_W         = 4;
   localparam int ADDRS_W        = 28;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 28;
   localparam int ACTIVE_W       = 4;
   localparam int BEAT_W         = 2;
   localparam int NIBBLE_W       = 4;
   localparam int COIL_W         = 8;

   localparam logic [BEAT_W-1:0] BEAT_LAST = 2'd3;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_MOVE,
      OP_SET,
      OP_READ
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOTOR_COUNT,
      CSR_NIBBLE_MASK,
      CSR_EXP_ADDR
   } csr_type;

   typedef enum logic {
      KIND_COIL,
      KIND_REPORT
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [MOTOR_W-1:0]      motor;
      logic signed [POS_W-1:0] value;
   } req_type;

   typedef struct packed {
      kind_type                kind;
      logic [IDX_W-1:0]        motor_index;
      logic [ADDR_W-1:0]       bus_address;
      logic [COIL_W-1:0]       coil_pattern;
      logic signed [POS_W-1:0] position;
      logic                    last;
   } rsp_type;

   // transaction travelling down the cell chain
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [MOTOR_W-1:0] motor;
      logic [POS_W-1:0]   value;
      logic [POS_W-1:0]   data;
   } token_type;

   typedef struct packed {
      logic step;
      logic up;
      logic busy;
   } cell_status_type;

   localparam logic [NIBBLE_W-1:0] COIL_SEQ [4] = '{4'hC, 4'h6, 4'h3, 4'h9};

   function automatic logic [COIL_W-1:0] coil_byte(input logic up,
                                                    input logic [BEAT_W-1:0] beat,
                                                    input logic high);
      logic [BEAT_W-1:0]   sel;
      logic [NIBBLE_W-1:0] pat;
      sel = up ? beat : (BEAT_LAST - beat);
      pat = COIL_SEQ[sel];
      return high ? {pat, 4'h0} : {4'h0, pat};
   endfunction

endpackage

[rtl/msps_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_cell
// One motor's position cell: holds current and target position, acts on the
// transaction passing through and hands it on to the next cell.
// ----------------------------------------------------------------------------
module msps_cell #(
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic [msps_pkg::ACTIVE_W-1:0]        active,
   input  msps_pkg::token_type                  token_in,
   output msps_pkg::token_type                  token_out,
   output msps_pkg::cell_status_type            status
);

   msps_pkg::token_type              token_ff;
   logic [msps_pkg::POS_W-1:0]       cur_ff, cur_in;
   logic [msps_pkg::POS_W-1:0]       tgt_ff, tgt_in;
   logic                             in_active;
   logic                             match;
   logic                             off;
   logic                             up;
   logic                             step;

   always_comb begin
      in_active = msps_pkg::ACTIVE_W'(INDEX) < active;
      match     = token_ff.motor == msps_pkg::MOTOR_W'(INDEX);
      off       = cur_ff != tgt_ff;
      up        = $signed(tgt_ff) > $signed(cur_ff);
      step      = token_ff.valid && (token_ff.op == msps_pkg::OP_TICK) && in_active && off;

      status.step = step;
      status.up   = up;
      status.busy = in_active && off;

      token_out = token_ff;
      if (token_ff.valid && (token_ff.op == msps_pkg::OP_READ) && match) begin
         token_out.data = cur_ff;
      end

      cur_in = cur_ff;
      tgt_in = tgt_ff;
      if (adv && token_ff.valid) begin
         unique case (token_ff.op)
            msps_pkg::OP_TICK: begin
               if (step) begin
                  cur_in = up ? cur_ff + 1'b1 : cur_ff - 1'b1;
               end
            end
            msps_pkg::OP_MOVE: begin
               if (match && in_active) begin
                  tgt_in = cur_ff + token_ff.value;
               end
            end
            msps_pkg::OP_SET: begin
               if (match) begin
                  cur_in = token_ff.value;
                  tgt_in = token_ff.value;
               end
            end
            msps_pkg::OP_READ: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
         cur_ff         <= '0;
         tgt_ff         <= '0;
      end else begin
         if (adv) begin
            token_ff <= token_in;
         end
         cur_ff <= cur_in;
         tgt_ff <= tgt_in;
      end
   end

endmodule

[rtl/multi_stepper_position_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stepper_position_sequencer_top
// Stepper position sequencer: a chain of per-motor cells that a transaction
// walks through, one cell per cycle unless the chain is held.
// ----------------------------------------------------------------------------
// Each accepted transaction enters cell 0 and moves one cell per cycle to the
// end of the chain unless the chain is held; a read's report then leaves
// through the output register. A tick holds at every active motor that is off
// target while that motor's four coil writes go out, and output stalls hold
// the chain too. One transaction is in flight at a time; the next is taken
// once the chain is empty again.
// ----------------------------------------------------------------------------
module multi_stepper_position_sequencer_top #(
   parameter int MOTORS = msps_pkg::MOTORS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  msps_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output msps_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [msps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   msps_pkg::state_type               state_ff, state_in;
   logic [msps_pkg::CNT_W-1:0]        motor_count_ff, motor_count_in;
   logic [msps_pkg::MASK_W-1:0]       mask_ff, mask_in;
   logic [msps_pkg::ADDRS_W-1:0]      exp_addr_ff, exp_addr_in;
   logic [msps_pkg::BEAT_W-1:0]       beat_ff, beat_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   msps_pkg::rsp_type                 rsp_ff, rsp_in;

   msps_pkg::token_type               token_chain [MOTORS+1];
   msps_pkg::cell_status_type         cell_status [MOTORS];
   logic [msps_pkg::ADDR_W-1:0]       cell_addr [MOTORS];
   logic [MOTORS-1:0]                 cell_high;
   logic [MOTORS-1:0]                 step_vec;

   logic [msps_pkg::ACTIVE_W-1:0]     active;
   logic                              accept;
   logic                              adv;
   logic                              free;
   logic                              tail_read;
   logic                              seen;
   logic                              later;
   logic [msps_pkg::MOTOR_W-1:0]      hold_idx;
   logic                              hold_up;
   logic                              hold_high;
   logic [msps_pkg::ADDR_W-1:0]       hold_addr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if ({1'b0, motor_count_ff} < msps_pkg::ACTIVE_W'(MOTORS)) begin
         active = {1'b0, motor_count_ff};
      end else begin
         active = msps_pkg::ACTIVE_W'(MOTORS);
      end
   end

   always_comb begin
      token_chain[0].valid = accept;
      token_chain[0].op    = req_data.op;
      token_chain[0].motor = req_data.motor;
      token_chain[0].value = req_data.value;
      token_chain[0].data  = '0;
   end

   genvar g;
   generate
      for (g = 0; g < MOTORS; g++) begin : g_cell
         msps_cell #(
            .INDEX (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .active    (active),
            .token_in  (token_chain[g]),
            .token_out (token_chain[g+1]),
            .status    (cell_status[g])
         );
         assign step_vec[g] = cell_status[g].step;
         if (g < msps_pkg::ADDR_SLOTS) begin : g_addr
            assign cell_addr[g] = exp_addr_ff[msps_pkg::ADDR_W*g +: msps_pkg::ADDR_W];
            assign cell_high[g] = mask_ff[g];
         end else begin : g_noaddr
            assign cell_addr[g] = '0;
            assign cell_high[g] = 1'b0;
         end
      end
   endgenerate

   // pick the cell that is stepping and see whether any later cell will step
   always_comb begin
      seen      = 1'b0;
      later     = 1'b0;
      hold_idx  = '0;
      hold_up   = 1'b0;
      hold_high = 1'b0;
      hold_addr = '0;
      for (int i = 0; i < MOTORS; i++) begin
         if (seen && cell_status[i].busy) begin
            later = 1'b1;
         end
         if (cell_status[i].step) begin
            seen      = 1'b1;
            hold_idx  = msps_pkg::MOTOR_W'(i);
            hold_up   = cell_status[i].up;
            hold_high = cell_high[i];
            hold_addr = cell_addr[i];
         end
      end
   end

   always_comb begin
      motor_count_in = motor_count_ff;
      mask_in        = mask_ff;
      exp_addr_in    = exp_addr_ff;
      if (csr_we) begin
         unique case (csr_index)
            msps_pkg::CSR_MOTOR_COUNT: motor_count_in = csr_wdata[msps_pkg::CNT_W-1:0];
            msps_pkg::CSR_NIBBLE_MASK: mask_in        = csr_wdata[msps_pkg::MASK_W-1:0];
            msps_pkg::CSR_EXP_ADDR:    exp_addr_in    = csr_wdata[msps_pkg::ADDRS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      free      = !rsp_valid_ff || !rsp_stall;
      tail_read = token_chain[MOTORS].valid && (token_chain[MOTORS].op == msps_pkg::OP_READ);
      adv       = (!(|step_vec) || (free && (beat_ff == msps_pkg::BEAT_LAST)))
                  && (!tail_read || free);

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      beat_in      = beat_ff;

      if ((|step_vec) && free) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = msps_pkg::KIND_COIL;
         rsp_in.motor_index  = hold_idx[msps_pkg::IDX_W-1:0];
         rsp_in.bus_address  = hold_addr;
         rsp_in.coil_pattern = msps_pkg::coil_byte(hold_up, beat_ff, hold_high);
         rsp_in.position     = '0;
         rsp_in.last         = (beat_ff == msps_pkg::BEAT_LAST) && !later;
         beat_in             = beat_ff + 1'b1;
      end else if (tail_read && free) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = msps_pkg::KIND_REPORT;
         rsp_in.motor_index  = token_chain[MOTORS].motor[msps_pkg::IDX_W-1:0];
         rsp_in.bus_address  = '0;
         rsp_in.coil_pattern = '0;
         rsp_in.position     = token_chain[MOTORS].data;
         rsp_in.last         = 1'b1;
      end

      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         msps_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = msps_pkg::ST_BUSY;
            end
         end
         msps_pkg::ST_BUSY: begin
            if (token_chain[MOTORS].valid && adv) begin
               state_in = msps_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= msps_pkg::ST_IDLE;
         motor_count_ff <= '0;
         mask_ff        <= '0;
         exp_addr_ff    <= '0;
         beat_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         motor_count_ff <= motor_count_in;
         mask_ff        <= mask_in;
         exp_addr_ff    <= exp_addr_in;
         beat_ff        <= beat_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

[tb/multi_stepper_position_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stepper_position_sequencer_top_tb
// Self-checking bench for the multi-stepper position sequencer.
// ----------------------------------------------------------------------------
// Drives tick, move, set and read commands with random pacing on both
// channels. A built-in model of the motor positions predicts every coil write
// and position report, which are checked field by field in order of arrival.
// Directed cases cover reset state, both step directions, position wrap,
// range bounds and register extremes; random phases follow under varying
// register settings.
// ----------------------------------------------------------------------------
module multi_stepper_position_sequencer_top_tb;
   import msps_pkg::*;

   localparam int MOTORS = MOTORS_DEFAULT;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 4 * MOTORS + 8;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 82;
   localparam logic [NIBBLE_W-1:0] FULL_STEP [4] = '{4'hC, 4'h6, 4'h3, 4'h9};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model state
   logic [POS_W-1:0] cur_pos [MOTORS];
   logic [POS_W-1:0] tgt_pos [MOTORS];
   logic [CNT_W-1:0] motor_cnt = '0;
   logic [MASK_W-1:0] nib_mask = '0;
   logic [ADDRS_W-1:0] exp_addr = '0;

   rsp_type due_rsp_q [$];
   int fail_count = 0;
   bit pace_on = 1'b1;
   int rsp_hold = 0;

   multi_stepper_position_sequencer_top #(
      .MOTORS(MOTORS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // expected coil writes and reports for one accepted transaction
   task automatic apply_command(input req_type cmd);
      int active;
      logic up;
      logic [NIBBLE_W-1:0] nib;
      rsp_type r;
      int n;
      active = (motor_cnt < MOTORS) ? motor_cnt : MOTORS;
      n = 0;
      case (cmd.op)
         OP_TICK: begin
            for (int i = 0; i < active; i++) begin
               if (cur_pos[i] != tgt_pos[i]) begin
                  up = $signed(tgt_pos[i]) > $signed(cur_pos[i]);
                  for (int s = 0; s < 4; s++) begin
                     nib = FULL_STEP[up ? s : 3 - s];
                     r = '0;
                     r.kind = KIND_COIL;
                     r.motor_index = i[IDX_W-1:0];
                     r.bus_address = exp_addr[ADDR_W*i +: ADDR_W];
                     r.coil_pattern = nib_mask[i] ? {nib, 4'h0} : {4'h0, nib};
                     due_rsp_q.push_back(r);
                     n++;
                  end
                  cur_pos[i] = up ? cur_pos[i] + 1 : cur_pos[i] - 1;
               end
            end
            if (n > 0) begin
               r = due_rsp_q.pop_back();
               r.last = 1'b1;
               due_rsp_q.push_back(r);
            end
         end
         OP_MOVE: begin
            if (cmd.motor < active)
               tgt_pos[cmd.motor[IDX_W-1:0]] = cur_pos[cmd.motor[IDX_W-1:0]] + cmd.value;
         end
         OP_SET: begin
            if (cmd.motor < MOTORS) begin
               cur_pos[cmd.motor[IDX_W-1:0]] = cmd.value;
               tgt_pos[cmd.motor[IDX_W-1:0]] = cmd.value;
            end
         end
         default: begin
            r = '0;
            r.kind = KIND_REPORT;
            r.motor_index = cmd.motor[IDX_W-1:0];
            r.position = (cmd.motor < MOTORS) ? cur_pos[cmd.motor[IDX_W-1:0]] : '0;
            r.last = 1'b1;
            due_rsp_q.push_back(r);
         end
      endcase
   endtask

   task automatic issue(input op_type op, input logic [MOTOR_W-1:0] motor,
                        input logic [POS_W-1:0] value);
      req_type cmd;
      int gap;
      cmd.op = op;
      cmd.motor = motor;
      cmd.value = value;
      gap = pace_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_stall);
      apply_command(cmd);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      settle_idle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_MOTOR_COUNT: motor_cnt = data[CNT_W-1:0];
         CSR_NIBBLE_MASK: nib_mask = data[MASK_W-1:0];
         CSR_EXP_ADDR:    exp_addr = data[ADDRS_W-1:0];
         default: ;
      endcase
   endtask

   function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                       input logic [POS_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp_q.size() == 0) begin
               $error("unexpected transaction: %p", rsp_data);
               fail_count++;
            end else begin
               want = due_rsp_q.pop_front();
               check_field("kind", POS_W'(want.kind), POS_W'(rsp_data.kind));
               check_field("motor_index", POS_W'(want.motor_index),
                           POS_W'(rsp_data.motor_index));
               check_field("bus_address", POS_W'(want.bus_address),
                           POS_W'(rsp_data.bus_address));
               check_field("coil_pattern", POS_W'(want.coil_pattern),
                           POS_W'(rsp_data.coil_pattern));
               check_field("position", want.position, rsp_data.position);
               check_field("last", POS_W'(want.last), POS_W'(rsp_data.last));
            end
            rsp_hold = pace_on ? $urandom_range(0, 7) : 0;
         end
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0)
            rsp_hold--;
      end
   end

   task automatic test_reset_defaults();
      issue(OP_READ, 3'd0, '0);
      issue(OP_READ, 3'd7, '0);
      issue(OP_MOVE, 3'd0, 32'd5);
      issue(OP_TICK, 3'd0, '0);
      issue(OP_READ, 3'd0, '0);
   endtask

   task automatic test_step_patterns();
      write_register(CSR_MOTOR_COUNT, 28'd4);
      write_register(CSR_NIBBLE_MASK, 28'h5);
      write_register(CSR_EXP_ADDR, {7'h11, 7'h7F, 7'h2A, 7'h55});
      issue(OP_SET, 3'd0, 32'h7FFF_FFFF);
      issue(OP_MOVE, 3'd0, 32'd1);
      issue(OP_MOVE, 3'd1, 32'd2);
      issue(OP_MOVE, 3'd2, 32'hFFFF_FFFF);
      issue(OP_SET, 3'd3, 32'h8000_0000);
      issue(OP_MOVE, 3'd3, 32'hFFFF_FFFF);
      issue(OP_TICK, 3'd0, '0);
      issue(OP_TICK, 3'd0, '0);
      for (int m = 0; m < MOTORS; m++)
         issue(OP_READ, m[MOTOR_W-1:0], '0);
   endtask

   task automatic test_range_bounds();
      write_register(CSR_MOTOR_COUNT, 28'd2);
      write_register(CSR_NIBBLE_MASK, 28'hA);
      write_register(CSR_EXP_ADDR, 28'hFFF_FFFF);
      issue(OP_MOVE, 3'd3, 32'd5);
      issue(OP_MOVE, 3'd1, 32'hFFFF_FFFE);
      issue(OP_SET, 3'd6, 32'h1234_5678);
      issue(OP_READ, 3'd5, '0);
      issue(OP_TICK, 3'd0, '0);
      write_register(CSR_MOTOR_COUNT, 28'd7);
      write_register(CSR_NIBBLE_MASK, 28'hF);
      write_register(CSR_EXP_ADDR, 28'h0);
      issue(OP_TICK, 3'd0, '0);
      issue(OP_READ, 3'd3, '0);
   endtask

   task automatic test_unused_register();
      write_register(CSR_UNUSED, 28'hFFF_FFFF);
      issue(OP_TICK, 3'd0, '0);
      issue(OP_READ, 3'd2, '0);
   endtask

   task automatic test_random_traffic();
      int pick;
      logic [POS_W-1:0] value;
      logic [MOTOR_W-1:0] motor;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       write_register(CSR_MOTOR_COUNT, 28'd4);
            1:       write_register(CSR_MOTOR_COUNT, CSR_DATA_W'($urandom_range(0, 7)));
            2:       write_register(CSR_MOTOR_COUNT, 28'd3);
            3:       write_register(CSR_MOTOR_COUNT, 28'd7);
            default: write_register(CSR_MOTOR_COUNT, 28'd4);
         endcase
         write_register(CSR_NIBBLE_MASK,
                        (phase == 3) ? 28'hF : CSR_DATA_W'($urandom_range(0, 15)));
         write_register(CSR_EXP_ADDR, (phase == 3) ? 28'hFFF_FFFF :
                        (phase == 4) ? 28'h0 :
                        CSR_DATA_W'($urandom_range(0, 28'hFFF_FFFF)));
         if ($urandom_range(0, 1))
            write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 28'hFFF_FFFF)));
         pace_on = (phase != 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            motor = ($urandom_range(0, 9) == 0) ? MOTOR_W'($urandom_range(0, 7)) :
                                                  MOTOR_W'($urandom_range(0, 3));
            if (pick < 40) begin
               issue(OP_TICK, MOTOR_W'($urandom_range(0, 7)), $urandom);
            end else if (pick < 65) begin
               value = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6) - 3;
               issue(OP_MOVE, motor, value);
            end else if (pick < 80) begin
               value = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 40) - 20;
               issue(OP_SET, motor, value);
            end else begin
               issue(OP_READ, MOTOR_W'($urandom_range(0, 7)), $urandom);
            end
         end
      end
      pace_on = 1'b1;
   endtask

   initial begin
      for (int m = 0; m < MOTORS; m++) begin
         cur_pos[m] = '0;
         tgt_pos[m] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_step_patterns();
      test_range_bounds();
      test_unused_register();
      test_random_traffic();
      settle_idle();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[multi_stepper_position_sequencer_top.f]
rtl/msps_pkg.sv
rtl/msps_cell.sv
rtl/multi_stepper_position_sequencer_top.sv
tb/multi_stepper_position_sequencer_top_tb.sv
